### rtl/core/ggvc_pkg.sv
// shared types, constants and the arctangent table of the go-to-goal controller
// no dependencies
`default_nettype none

package ggvc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_STAGES        = 24;

   localparam int POS_W  = 18;
   localparam int ANG_W  = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int XY_W   = 30;
   localparam int Z_W    = 20;
   localparam int DIST_W = 20;
   localparam int ERR_W  = 19;

   localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

   typedef enum logic [2:0] {
      CSR_LINEAR_GAIN      = 3'd0,
      CSR_MAX_LINEAR_SPEED = 3'd1,
      CSR_ANGULAR_GAIN     = 3'd2,
      CSR_MAX_ANGULAR_RATE = 3'd3,
      CSR_HEADING_WINDOW   = 3'd4,
      CSR_STOP_DISTANCE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] max_linear_speed;
      logic [15:0] angular_gain;
      logic [14:0] max_angular_rate;
      logic [14:0] heading_window;
      logic [15:0] stop_distance;
   } cfg_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic signed [ANG_W-1:0] heading;
      logic                    zero;
   } cordic_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic [16:0] atan_q16(input logic [4:0] idx);
      logic [16:0] r;
      unique case (idx)
         5'd0:    r = 17'd51472;
         5'd1:    r = 17'd30386;
         5'd2:    r = 17'd16055;
         5'd3:    r = 17'd8150;
         5'd4:    r = 17'd4091;
         5'd5:    r = 17'd2047;
         5'd6:    r = 17'd1024;
         5'd7:    r = 17'd512;
         5'd8:    r = 17'd256;
         5'd9:    r = 17'd128;
         5'd10:   r = 17'd64;
         5'd11:   r = 17'd32;
         5'd12:   r = 17'd16;
         5'd13:   r = 17'd8;
         5'd14:   r = 17'd4;
         5'd15:   r = 17'd2;
         5'd16:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ggvc_front.sv
// input stage: goal vector, q.20 scaling and left half plane pre-rotation
// depends on ggvc_pkg
`default_nettype none

module ggvc_front import ggvc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [POS_W-1:0] pos_x,
   input  wire logic signed [POS_W-1:0] pos_y,
   input  wire logic signed [ANG_W-1:0] heading,
   input  wire logic signed [POS_W-1:0] goal_x,
   input  wire logic signed [POS_W-1:0] goal_y,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output cordic_type                   out_data
);

   logic       valid_ff;
   cordic_type data_ff, data_in;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [XY_W-1:0]   x0, y0;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dx = {goal_x[POS_W-1], goal_x} - {pos_x[POS_W-1], pos_x};
      dy = {goal_y[POS_W-1], goal_y} - {pos_y[POS_W-1], pos_y};
      x0 = {{(XY_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0};
      y0 = {{(XY_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0};
      data_in.heading = heading;
      data_in.zero    = (dx == '0) && (dy == '0);
      if (x0 < 0) begin
         if (y0 >= 0) begin
            data_in.x = y0;
            data_in.y = -x0;
            data_in.z = HALF_PI_Q16;
         end else begin
            data_in.x = -y0;
            data_in.y = x0;
            data_in.z = -HALF_PI_Q16;
         end
      end else begin
         data_in.x = x0;
         data_in.y = y0;
         data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### rtl/core/ggvc_cordic_cell.sv
// one vectoring cordic micro-rotation with its pipeline register
// depends on ggvc_pkg
`default_nettype none

module ggvc_cordic_cell import ggvc_pkg::*; #(
   parameter int STAGE = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cordic_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output cordic_type      out_data
);

   logic       valid_ff;
   cordic_type data_ff, data_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  angle;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs    = in_data.x >>> STAGE;
      ys    = in_data.y >>> STAGE;
      angle = {{(Z_W-17){1'b0}}, atan_q16(5'(STAGE))};
      data_in = in_data;
      if (in_data.y > 0) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + angle;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### rtl/core/ggvc_back.sv
// output stages: distance scaling, bearing, angle wrap, gains, clamps
// depends on ggvc_pkg
`default_nettype none

module ggvc_back import ggvc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire cordic_type  in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [15:0]      linear_speed,
   output logic signed [15:0] angular_rate
);

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic ra, rb, rc, rd;

   assign rd = !vd_ff || out_ready;
   assign rc = !vc_ff || rd;
   assign rb = !vb_ff || rc;
   assign ra = !va_ff || rb;
   assign in_ready = ra;

   // stage a: distance product and raw error
   logic [XY_W-2:0]          xc;
   logic [58:0]              prod;
   logic signed [Z_W:0]      zr;
   logic signed [ERR_W-1:0]  bear;
   logic [DIST_W-1:0]        dist_a_ff, dist_a_in;
   logic signed [ERR_W-1:0]  err_a_ff, err_a_in;

   always_comb begin
      xc   = in_data.x[XY_W-1] ? '0 : in_data.x[XY_W-2:0];
      prod = 59'(xc) * 59'(INV_GAIN_Q30) + (59'd1 << 37);
      zr   = {in_data.z[Z_W-1], in_data.z} + 21'sd4;
      bear = in_data.zero ? '0 : ERR_W'(zr >>> 3);
      dist_a_in = in_data.zero ? '0 : prod[38+DIST_W-1:38];
      err_a_in  = ERR_W'(in_data.heading) - bear;
   end

   // stage b: wrap once and linear gain product
   logic [ERR_W-1:0]         err_mag;
   logic signed [ERR_W-1:0]  err_b_ff, err_b_in;
   logic [DIST_W-1:0]        dist_b_ff;
   logic [35:0]              lin_prod_ff, lin_prod_in;

   always_comb begin
      err_mag = err_a_ff[ERR_W-1] ? ERR_W'(-err_a_ff) : ERR_W'(err_a_ff);
      err_b_in = err_a_ff;
      if (err_mag > ERR_W'(PI_Q13)) begin
         if (err_a_ff > 0) err_b_in = err_a_ff - TWO_PI_Q13;
         else              err_b_in = err_a_ff + TWO_PI_Q13;
      end
      lin_prod_in = 36'(cfg.linear_gain) * 36'(dist_a_ff);
   end

   // stage c: linear speed final, angular gain product, stop flag
   logic [ERR_W-1:0]         err_b_mag;
   logic [36:0]              lin_sum;
   logic [24:0]              lin_q;
   logic [15:0]              lin_c_ff, lin_c_in;
   logic signed [36:0]       ang_sum;
   logic signed [23:0]       ang_c_ff, ang_c_in;
   logic                     stop_c_ff, stop_c_in;

   always_comb begin
      err_b_mag = err_b_ff[ERR_W-1] ? ERR_W'(-err_b_ff) : ERR_W'(err_b_ff);
      lin_sum   = {1'b0, lin_prod_ff} + 37'd2048;
      lin_q     = lin_sum[36:12];
      if (lin_q > 25'(cfg.max_linear_speed)) lin_c_in = cfg.max_linear_speed;
      else                                   lin_c_in = lin_q[15:0];
      if (err_b_mag > ERR_W'(cfg.heading_window)) lin_c_in = '0;
      ang_sum  = 37'(err_b_ff) * 37'(signed'({1'b0, cfg.angular_gain})) + 37'sd4096;
      ang_c_in = 24'(ang_sum >>> 13);
      stop_c_in = dist_b_ff < DIST_W'(cfg.stop_distance);
   end

   // stage d: symmetric clamp and negation
   logic signed [23:0]       lim;
   logic signed [15:0]       ang_d_in;
   logic signed [15:0]       ang_d_ff;
   logic [15:0]              lin_d_ff;

   always_comb begin
      lim = 24'(signed'({1'b0, cfg.max_angular_rate}));
      if (ang_c_ff > lim)       ang_d_in = -16'(lim);
      else if (ang_c_ff < -lim) ang_d_in = 16'(lim);
      else                      ang_d_in = -16'(ang_c_ff);
      if (stop_c_ff) ang_d_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (ra) va_ff <= in_valid;
         if (rb) vb_ff <= va_ff;
         if (rc) vc_ff <= vb_ff;
         if (rd) vd_ff <= vc_ff;
      end
      if (ra && in_valid) begin
         dist_a_ff <= dist_a_in;
         err_a_ff  <= err_a_in;
      end
      if (rb && va_ff) begin
         err_b_ff    <= err_b_in;
         dist_b_ff   <= dist_a_ff;
         lin_prod_ff <= lin_prod_in;
      end
      if (rc && vb_ff) begin
         lin_c_ff  <= lin_c_in;
         ang_c_ff  <= ang_c_in;
         stop_c_ff <= stop_c_in;
      end
      if (rd && vc_ff) begin
         lin_d_ff <= lin_c_ff;
         ang_d_ff <= ang_d_in;
      end
   end

   assign out_valid    = vd_ff;
   assign linear_speed = lin_d_ff;
   assign angular_rate = ang_d_ff;

endmodule

`default_nettype wire

### rtl/core/go_to_goal_velocity_controller.sv
// go-to-goal velocity controller for a unicycle robot, top level
// holds the register file; depends on ggvc_pkg, ggvc_front, ggvc_cordic_cell, ggvc_back
//
// usage: a pose and goal enter on the req_ stream, one speed and turn rate leave on the
// rsp_ stream for each transfer, in order. registers are written on the csr_ port with
// csr_we high for one cycle, only while no item is in flight.
// pipeline: one input stage, one register per cordic cell (16 at the default), and four
// output stages, the input stage loading at the transfer edge itself.
// throughput: one item per cycle; every stage is its own register with a valid bit, so a
// new item enters each cycle while the receiver keeps up.
// stall: a low rsp_tready holds the result; bubbles in the chain still close up, and
// req_tready drops only once every stage holds an item.
// reset: synchronous; empties the chain and loads the register defaults.
// linear_speed is Q.12 m/s; angular_rate is signed Q.12 rad/s.
`default_nettype none

module go_to_goal_velocity_controller import ggvc_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_x[17:0], pos_y[35:18], heading[51:36], goal_x[69:52], goal_y[87:70]
   input  wire logic [87:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // linear_speed[15:0], angular_rate[31:16]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int STAGES = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain      <= 16'd4096;
         cfg_ff.max_linear_speed <= 16'd1024;
         cfg_ff.angular_gain     <= 16'd40960;
         cfg_ff.max_angular_rate <= 15'd11551;
         cfg_ff.heading_window   <= 15'd6434;
         cfg_ff.stop_distance    <= 16'd410;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINEAR_GAIN:      cfg_ff.linear_gain      <= csr_data;
            CSR_MAX_LINEAR_SPEED: cfg_ff.max_linear_speed <= csr_data;
            CSR_ANGULAR_GAIN:     cfg_ff.angular_gain     <= csr_data;
            CSR_MAX_ANGULAR_RATE: cfg_ff.max_angular_rate <= csr_data[14:0];
            CSR_HEADING_WINDOW:   cfg_ff.heading_window   <= csr_data[14:0];
            CSR_STOP_DISTANCE:    cfg_ff.stop_distance    <= csr_data;
            default: ;
         endcase
      end
   end

   cordic_type        chain_data  [STAGES+1];
   logic [STAGES:0]   chain_valid;
   logic [STAGES:0]   chain_ready;

   ggvc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pos_x     (req_tdata[17:0]),
      .pos_y     (req_tdata[35:18]),
      .heading   (req_tdata[51:36]),
      .goal_x    (req_tdata[69:52]),
      .goal_y    (req_tdata[87:70]),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      ggvc_cordic_cell #(.STAGE(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   logic [15:0]        lin;
   logic signed [15:0] ang;

   ggvc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (chain_valid[STAGES]),
      .in_ready     (chain_ready[STAGES]),
      .in_data      (chain_data[STAGES]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .linear_speed (lin),
      .angular_rate (ang)
   );

   assign rsp_tdata = {ang, lin};

`ifndef SYNTH
   // an empty output register lets the whole chain move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // clamp then negate never reaches the most negative code
   a_rate_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] != 16'h8000)
      else $error("angular rate out of symmetric range");
`endif

endmodule

`default_nettype wire
